// ===== src/hotplug_presence_debouncer_macros.svh =====
// Assertion macros for the hotplug presence debouncer.
// Used by the top level only; no other dependencies.
`ifndef HOTPLUG_PRESENCE_DEBOUNCER_MACROS_SVH
`define HOTPLUG_PRESENCE_DEBOUNCER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HPD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HPD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HPD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define HPD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/hpd_pkg.sv =====
// Package for the hotplug presence debouncer: payload structs, slot phase
// codes, command and register codes. No dependencies.
package hpd_pkg;

  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned MAX_SLOTS  = 4;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam logic [30:0] DELAY_RESET    = 31'd50;
  localparam logic [2:0]  CAPACITY_RESET = 3'd4;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // register index = paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_DELAY    = 1'b0;
  localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b1;

  typedef enum logic [3:0] {
    PH_EMPTY     = 4'b0001,
    PH_INS_DB    = 4'b0010,
    PH_PRESENT   = 4'b0100,
    PH_REM_DB    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [3:0]  present_mask;
    logic [3:0]  edge_flags;
    logic [31:0] edge_time_slot0;
    logic [31:0] edge_time_slot1;
    logic [31:0] edge_time_slot2;
    logic [31:0] edge_time_slot3;
  } in_t;

  typedef struct packed {
    logic [3:0]  inserted_mask;
    logic [3:0]  removed_mask;
    logic [2:0]  num_events;
    logic [31:0] event_time;
    logic [3:0]  stable_present_mask;
    logic [3:0]  debounce_pending_mask;
  } out_t;

endpackage

// ===== src/hotplug_presence_debouncer.sv =====
// Hotplug presence debouncer top level: per-slot debounce machines, APB
// registers, input and result registers. Depends on hpd_pkg and the macros header.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+--------------------------
//  in       | in  | in_valid_i/in_ready_o | in_data_i  (hpd_pkg::in_t)
//  out      | out | out_valid_o/out_ready_i | out_data_o (hpd_pkg::out_t)
//  cfg      | in  | psel/penable/pwrite   | paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled; the result passes the input
// register, then the slot update into the result register, before it can be taken.
// The slot state updates with the result register, so polls chain back to back.
// With the output stalled the input register still takes one more transfer.
// Reset puts every slot in the empty phase and the registers at 50 ms / 4.

`include "hotplug_presence_debouncer_macros.svh"

module hotplug_presence_debouncer #(
  parameter int unsigned SlotCount = hpd_pkg::SLOT_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hpd_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output hpd_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [hpd_pkg::DATA_W-1:0]  pwdata,
  output logic [hpd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [30:0] delay_q;
  logic [2:0]  cap_q;

  hpd_pkg::in_t  in_q;
  logic          in_valid_q;
  hpd_pkg::out_t out_q, res;
  logic          out_valid_q;
  logic          advance;

  hpd_pkg::phase_e phase_q [SlotCount];
  hpd_pkg::phase_e phase_d [SlotCount];
  logic [31:0]     time_q  [SlotCount];
  logic [31:0]     time_d  [SlotCount];

  // ---------------- configuration ----------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= hpd_pkg::DELAY_RESET;
      cap_q   <= hpd_pkg::CAPACITY_RESET;
    end else if (cfg_wr) begin
      case (paddr[hpd_pkg::ADDR_W-1:2])
        hpd_pkg::REG_DELAY:    delay_q <= pwdata[30:0];
        hpd_pkg::REG_CAPACITY: cap_q   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[hpd_pkg::ADDR_W-1:2])
      hpd_pkg::REG_DELAY:    prdata = {1'b0, delay_q};
      hpd_pkg::REG_CAPACITY: prdata = {29'd0, cap_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= res;
    end
  end

  // ---------------- slot machines ----------------
  always_comb begin
    logic [31:0] et [hpd_pkg::MAX_SLOTS];
    logic        pres;
    logic        edg;
    logic [31:0] start;
    logic [31:0] diff;
    logic        elapsed;
    logic        ev_ins;
    logic        ev_rem;
    logic [2:0]  cnt;

    et[0] = in_q.edge_time_slot0;
    et[1] = in_q.edge_time_slot1;
    et[2] = in_q.edge_time_slot2;
    et[3] = in_q.edge_time_slot3;
    res   = '0;
    res.event_time = in_q.now_ms;
    cnt   = '0;

    for (int i = 0; i < SlotCount; i++) begin
      pres    = in_q.present_mask[i];
      edg     = in_q.edge_flags[i];
      start   = edg ? et[i] : time_q[i];
      diff    = in_q.now_ms - start;
      // negative difference never counts as elapsed
      elapsed = !diff[31] && (diff[30:0] >= delay_q);
      ev_ins  = 1'b0;
      ev_rem  = 1'b0;
      phase_d[i] = phase_q[i];
      time_d[i]  = time_q[i];

      if (in_q.command == hpd_pkg::CMD_INIT) begin
        phase_d[i] = pres ? hpd_pkg::PH_PRESENT : hpd_pkg::PH_EMPTY;
        time_d[i]  = in_q.now_ms;
      end else begin
        case (phase_q[i])
          hpd_pkg::PH_EMPTY: begin
            if (pres) begin
              phase_d[i] = hpd_pkg::PH_INS_DB;
              time_d[i]  = edg ? et[i] : in_q.now_ms;
            end
          end
          hpd_pkg::PH_INS_DB: begin
            if (!pres) begin
              phase_d[i] = hpd_pkg::PH_EMPTY;
              time_d[i]  = in_q.now_ms;
            end else if (elapsed) begin
              phase_d[i] = hpd_pkg::PH_PRESENT;
              time_d[i]  = in_q.now_ms;
              ev_ins     = 1'b1;
            end else begin
              time_d[i]  = start;
            end
          end
          hpd_pkg::PH_PRESENT: begin
            if (!pres) begin
              phase_d[i] = hpd_pkg::PH_REM_DB;
              time_d[i]  = edg ? et[i] : in_q.now_ms;
            end
          end
          hpd_pkg::PH_REM_DB: begin
            if (pres) begin
              phase_d[i] = hpd_pkg::PH_PRESENT;
              time_d[i]  = in_q.now_ms;
            end else if (elapsed) begin
              phase_d[i] = hpd_pkg::PH_EMPTY;
              time_d[i]  = in_q.now_ms;
              ev_rem     = 1'b1;
            end else begin
              time_d[i]  = start;
            end
          end
          default: begin
            phase_d[i] = hpd_pkg::PH_EMPTY;
            time_d[i]  = in_q.now_ms;
          end
        endcase
      end

      // events reported in slot order up to the capacity
      if ((ev_ins || ev_rem) && (cnt < cap_q)) begin
        res.inserted_mask[i] = ev_ins;
        res.removed_mask[i]  = ev_rem;
        cnt = cnt + 3'd1;
      end

      res.stable_present_mask[i]   = (phase_d[i] == hpd_pkg::PH_PRESENT) ||
                                     (phase_d[i] == hpd_pkg::PH_REM_DB);
      res.debounce_pending_mask[i] = (phase_d[i] == hpd_pkg::PH_INS_DB) ||
                                     (phase_d[i] == hpd_pkg::PH_REM_DB);
    end
    res.num_events = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        phase_q[i] <= hpd_pkg::PH_EMPTY;
        time_q[i]  <= '0;
      end
    end else if (advance && in_valid_q) begin
      for (int i = 0; i < SlotCount; i++) begin
        phase_q[i] <= phase_d[i];
        time_q[i]  <= time_d[i];
      end
    end
  end

  // ---------------- assertions ----------------
  `HPD_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled while a stage is free")
  `HPD_ASSERT_IMP(a_count_matches, clk_i, rst_ni, out_valid_o, $countones(out_data_o.inserted_mask | out_data_o.removed_mask) == out_data_o.num_events, "event count differs from masks")
  `HPD_ASSERT_IMP(a_count_capped, clk_i, rst_ni, out_valid_o, out_data_o.num_events <= cap_q, "event count above capacity")
  `HPD_ASSERT_IMP(a_event_vs_stable, clk_i, rst_ni, out_valid_o, ((out_data_o.inserted_mask & ~out_data_o.stable_present_mask) == 4'd0) && ((out_data_o.removed_mask & out_data_o.stable_present_mask) == 4'd0), "event disagrees with stable presence")

endmodule

// ===== tb/hotplug_presence_debouncer_test.sv =====
// Self-checking testbench for the hotplug presence debouncer: a scoreboard
// predicts every result and checks it, while plain tasks drive the input and APB ports.
// Depends on hpd_pkg and the hotplug_presence_debouncer top level.
module hotplug_presence_debouncer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned LATENCY    = 2;

  localparam logic [30:0] DELAY_PLAN [PHASES] = '{
    31'd0, 31'd4, 31'd10, 31'd1, 31'h7FFF_FFFF, 31'd20, 31'd6, 31'd3
  };
  localparam logic [2:0] CAP_PLAN [PHASES] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd7, 3'd4, 3'd4
  };

  typedef enum logic [1:0] {
    EV_NONE,
    EV_INSERT,
    EV_REMOVE
  } slot_event_e;

  // Slot debounce predictor plus the queue of results it expects.
  class debounce_scoreboard;
    hpd_pkg::phase_e slot_state [hpd_pkg::SLOT_COUNT];
    logic [31:0]     slot_mark  [hpd_pkg::SLOT_COUNT];
    logic [3:0]      settled;
    logic [30:0]     delay_cfg;
    logic [2:0]      capacity;
    hpd_pkg::out_t   expected_q [$];
    int unsigned     errors;

    function new();
      for (int i = 0; i < hpd_pkg::SLOT_COUNT; i++) begin
        slot_state[i] = hpd_pkg::PH_EMPTY;
        slot_mark[i]  = '0;
      end
      settled   = '0;
      delay_cfg = hpd_pkg::DELAY_RESET;
      capacity  = hpd_pkg::CAPACITY_RESET;
      errors    = 0;
    endfunction

    // wrap-safe: a negative difference never counts as elapsed
    function bit settle_due(logic [31:0] now, logic [31:0] start);
      logic [31:0] diff;
      diff = now - start;
      return !diff[31] && (diff >= {1'b0, delay_cfg});
    endfunction

    function void set_register(logic [hpd_pkg::ADDR_W-3:0] idx, logic [31:0] value);
      if (idx == hpd_pkg::REG_DELAY) delay_cfg = value[30:0];
      else if (idx == hpd_pkg::REG_CAPACITY) capacity = value[2:0];
    endfunction

    function void note_input(hpd_pkg::in_t it);
      hpd_pkg::out_t r;
      logic [31:0]   stamp [hpd_pkg::SLOT_COUNT];
      logic          pres;
      logic          has_edge;
      int unsigned   count;
      slot_event_e   ev;
      stamp = '{it.edge_time_slot0, it.edge_time_slot1, it.edge_time_slot2,
                it.edge_time_slot3};
      r = '0;
      r.event_time = it.now_ms;
      count = 0;
      for (int i = 0; i < hpd_pkg::SLOT_COUNT; i++) begin
        pres     = it.present_mask[i];
        has_edge = it.edge_flags[i];
        ev       = EV_NONE;
        if (it.command == hpd_pkg::CMD_INIT) begin
          slot_state[i] = pres ? hpd_pkg::PH_PRESENT : hpd_pkg::PH_EMPTY;
          settled[i]    = pres;
          slot_mark[i]  = it.now_ms;
        end else begin
          case (slot_state[i])
            hpd_pkg::PH_EMPTY: begin
              if (pres) begin
                slot_state[i] = hpd_pkg::PH_INS_DB;
                slot_mark[i]  = has_edge ? stamp[i] : it.now_ms;
              end
            end
            hpd_pkg::PH_INS_DB: begin
              if (!pres) begin
                slot_state[i] = hpd_pkg::PH_EMPTY;
                slot_mark[i]  = it.now_ms;
              end else begin
                if (has_edge) slot_mark[i] = stamp[i];
                if (settle_due(it.now_ms, slot_mark[i])) begin
                  settled[i]    = 1'b1;
                  slot_state[i] = hpd_pkg::PH_PRESENT;
                  slot_mark[i]  = it.now_ms;
                  ev            = EV_INSERT;
                end
              end
            end
            hpd_pkg::PH_PRESENT: begin
              if (!pres) begin
                slot_state[i] = hpd_pkg::PH_REM_DB;
                slot_mark[i]  = has_edge ? stamp[i] : it.now_ms;
              end
            end
            default: begin
              if (pres) begin
                slot_state[i] = hpd_pkg::PH_PRESENT;
                slot_mark[i]  = it.now_ms;
              end else begin
                if (has_edge) slot_mark[i] = stamp[i];
                if (settle_due(it.now_ms, slot_mark[i])) begin
                  settled[i]    = 1'b0;
                  slot_state[i] = hpd_pkg::PH_EMPTY;
                  slot_mark[i]  = it.now_ms;
                  ev            = EV_REMOVE;
                end
              end
            end
          endcase
          // phase changes stand even when the event is dropped
          if (ev != EV_NONE && count < capacity) begin
            if (ev == EV_INSERT) r.inserted_mask[i] = 1'b1;
            else r.removed_mask[i] = 1'b1;
            count++;
          end
        end
        r.stable_present_mask[i]   = settled[i];
        r.debounce_pending_mask[i] = (slot_state[i] == hpd_pkg::PH_INS_DB) ||
                                     (slot_state[i] == hpd_pkg::PH_REM_DB);
      end
      r.num_events = count[2:0];
      expected_q.push_back(r);
    endfunction

    function int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(hpd_pkg::out_t got);
      hpd_pkg::out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      errors += field_diff("inserted_mask", want.inserted_mask, got.inserted_mask);
      errors += field_diff("removed_mask", want.removed_mask, got.removed_mask);
      errors += field_diff("num_events", want.num_events, got.num_events);
      errors += field_diff("event_time", want.event_time, got.event_time);
      errors += field_diff("stable_present_mask", want.stable_present_mask,
                           got.stable_present_mask);
      errors += field_diff("debounce_pending_mask", want.debounce_pending_mask,
                           got.debounce_pending_mask);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_ready;
  hpd_pkg::in_t               in_data;
  logic                       out_valid;
  logic                       out_ready;
  hpd_pkg::out_t              out_data;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [hpd_pkg::ADDR_W-1:0] paddr;
  logic [hpd_pkg::DATA_W-1:0] pwdata;
  logic [hpd_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  debounce_scoreboard sb;
  int unsigned        gap_pct;
  bit                 quiet;
  logic [31:0]        sim_ms;
  logic [3:0]         line_level;

  always #2 clk = ~clk;

  hotplug_presence_debouncer dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // result-side back-pressure in random bursts
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL hotplug_presence_debouncer");
    $finish;
  end

  function automatic hpd_pkg::in_t mk(logic cmd, logic [31:0] now, logic [3:0] pres,
                                      logic [3:0] edges, logic [31:0] s0,
                                      logic [31:0] s1, logic [31:0] s2,
                                      logic [31:0] s3);
    hpd_pkg::in_t it;
    it.command         = cmd;
    it.now_ms          = now;
    it.present_mask    = pres;
    it.edge_flags      = edges;
    it.edge_time_slot0 = s0;
    it.edge_time_slot1 = s1;
    it.edge_time_slot2 = s2;
    it.edge_time_slot3 = s3;
    return it;
  endfunction

  // Mostly plausible poll sequences: time moves forward, lines bounce, edges
  // are stamped a little in the past; some items are pure noise.
  function automatic hpd_pkg::in_t next_item(int unsigned span);
    hpd_pkg::in_t it;
    int unsigned  pick;
    logic [31:0]  stamp [4];
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      return mk(1'($urandom), $urandom, 4'($urandom), 4'($urandom), $urandom,
                $urandom, $urandom, $urandom);
    end
    sim_ms += $urandom_range(0, span);
    for (int i = 0; i < 4; i++) begin
      stamp[i] = sim_ms - $urandom_range(0, span);
      if ($urandom_range(0, 5) == 0) begin
        line_level[i]    = ~line_level[i];
        it.edge_flags[i] = ($urandom_range(0, 3) != 0);
      end else begin
        it.edge_flags[i] = ($urandom_range(0, 9) == 0);
      end
      if ($urandom_range(0, 15) == 0) stamp[i] = sim_ms + $urandom_range(1, span + 1);
    end
    return mk((pick < 11) ? hpd_pkg::CMD_INIT : hpd_pkg::CMD_POLL, sim_ms, line_level,
              it.edge_flags, stamp[0], stamp[1], stamp[2], stamp[3]);
  endfunction

  task automatic push(hpd_pkg::in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // first edge lets the monitor log the last transfer
  task automatic drain();
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [hpd_pkg::ADDR_W-3:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus returns to idle between transfers
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  initial begin
    int unsigned span;
    sb         = new();
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    gap_pct    = 15;
    quiet      = 1'b0;
    sim_ms     = '0;
    line_level = '0;
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // reset settings: 50 ms, four events
    push(mk(hpd_pkg::CMD_POLL, 32'd0, 4'h0, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd5, 4'hF, 4'hF, '1, '1, '1, '1));
    push(mk(hpd_pkg::CMD_POLL, 32'd55, 4'hF, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_INIT, 32'd100, 4'b1010, 4'hF, 32'h1234_5678, '1,
            32'h8000_0000, '0));
    // slot 2 gets an edge stamp ahead of now
    push(mk(hpd_pkg::CMD_POLL, 32'd110, 4'hF, 4'b0101, 32'd105, '0, 32'd200, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd154, 4'hF, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd155, 4'hF, 4'h0, '0, '0, '0, '0));
    // new edge during insert debounce restarts the wait
    push(mk(hpd_pkg::CMD_POLL, 32'd160, 4'hF, 4'b0100, '0, '0, 32'd150, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd200, 4'hF, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd210, 4'h0, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd230, 4'b0001, 4'b0010, '0, 32'd225, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd260, 4'h0, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd275, 4'h0, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd310, 4'h0, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_INIT, 32'hFFFF_FFF0, 4'hF, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_INIT, 32'hFFFF_FFF0, 4'h0, 4'h0, '0, '0, '0, '0));
    // debounce across the 32-bit wrap
    push(mk(hpd_pkg::CMD_POLL, 32'hFFFF_FFF0, 4'hF, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'h0000_0021, 4'hF, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'h0000_0022, 4'hF, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'hFFFF_FFFF, 4'h0, 4'hF, '0, '0, '0, '0));
    in_valid <= 1'b0;
    drain();

    // longest delay: settles only at a difference of exactly 2^31-1
    write_reg(hpd_pkg::REG_DELAY, 32'h7FFF_FFFF);
    push(mk(hpd_pkg::CMD_INIT, 32'd0, 4'h0, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'd0, 4'b0001, 4'b0001, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'h7FFF_FFFE, 4'b0001, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'h7FFF_FFFF, 4'b0001, 4'h0, '0, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'h7FFF_FFFF, 4'h0, 4'b0001, '1, '0, '0, '0));
    push(mk(hpd_pkg::CMD_POLL, 32'h8000_0000, 4'h0, 4'h0, '0, '0, '0, '0));
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(hpd_pkg::REG_DELAY, {1'b0, DELAY_PLAN[p]});
      write_reg(hpd_pkg::REG_CAPACITY, {29'd0, CAP_PLAN[p]});
      span       = (DELAY_PLAN[p] > 800) ? 400 : DELAY_PLAN[p] / 2 + 2;
      sim_ms     = (p == 5) ? 32'hFFFF_FF00 : $urandom;
      line_level = 4'($urandom);
      gap_pct    = (p % 3 == 2) ? 0 : 12;
      if (p == PHASES - 1) begin
        gap_pct = 0;
        quiet   = 1'b1;
      end
      repeat (PHASE_ITEMS) push(next_item(span));
      in_valid <= 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS hotplug_presence_debouncer");
    end else begin
      $display("FAIL hotplug_presence_debouncer");
    end
    $finish;
  end

endmodule
